// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== sv/imp_pkg.sv =====
// shared types and constants for the integer matrix power block
package imp_pkg;

    localparam int DIM     = 4;
    localparam int IDX_W   = $clog2(DIM);
    localparam int ELEM_W  = 2 * IDX_W;
    localparam int CNT_W   = 3 * IDX_W;
    localparam int SLOT_W  = 2;
    localparam int ADDR_W  = SLOT_W + ELEM_W;
    localparam int DATA_W  = 32;
    localparam int POW_W   = 31;

    typedef logic [SLOT_W-1:0] slot_t;

    // slot 0 holds the loaded base, slots 1 to 3 are working matrices
    localparam slot_t BASE_SLOT = slot_t'(0);

    typedef struct packed {
        logic  load;
        logic  mul_go;
        logic  emit_go;
        logic  ident;
        slot_t a_slot;
        slot_t b_slot;
        slot_t d_slot;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic emit_done;
    } sts_t;

endpackage

// ===== sv/imp_dpath.sv =====
// datapath: matrix memory, multiply-accumulate pipeline and result output
`include "assert_macros.svh"

module imp_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imp_pkg::cmd_t                       cmd,
    input  logic [imp_pkg::IDX_W-1:0]           row,
    input  logic [imp_pkg::IDX_W-1:0]           col,
    input  logic signed [imp_pkg::DATA_W-1:0]   value,
    output imp_pkg::sts_t                       sts,
    output logic                                out_valid,
    output logic [imp_pkg::IDX_W-1:0]           out_row,
    output logic [imp_pkg::IDX_W-1:0]           out_col,
    output logic signed [imp_pkg::DATA_W-1:0]   out_value,
    output logic                                last
);
    import imp_pkg::*;

    localparam logic [CNT_W-1:0]  MUL_LAST  = {CNT_W{1'b1}};
    localparam logic [ELEM_W-1:0] ELEM_LAST = {ELEM_W{1'b1}};
    localparam logic [IDX_W-1:0]  K_LAST    = {IDX_W{1'b1}};

    logic [DATA_W-1:0]   mem [2**ADDR_W];
    logic [DATA_W-1:0]   rd0_reg;
    logic [DATA_W-1:0]   rd1_reg;
    logic [ADDR_W-1:0]   raddr0;
    logic [ADDR_W-1:0]   raddr1;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;

    logic                mul_act_reg;
    logic                emit_act_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                s1_mul_reg;
    logic                s1_emit_reg;
    logic [IDX_W-1:0]    s1_k_reg;
    logic [ELEM_W-1:0]   s1_e_reg;

    logic                s2_mul_reg;
    logic [IDX_W-1:0]    s2_k_reg;
    logic [ELEM_W-1:0]   s2_e_reg;
    logic [DATA_W-1:0]   prod_reg;
    logic [DATA_W-1:0]   prod_full;

    logic [DATA_W-1:0]   sum_reg;
    logic [DATA_W-1:0]   sum_next;
    logic                sum_wr;

    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_row_reg;
    logic [IDX_W-1:0]    out_col_reg;
    logic [DATA_W-1:0]   out_value_reg;
    logic                last_reg;
    logic [DATA_W-1:0]   emit_value;

    // product element (r, c) walks k fastest: cnt = {r, c, k}
    always_comb
    begin
        if (emit_act_reg)
        begin
            raddr0 = {cmd.a_slot, cnt_reg[ELEM_W-1:0]};
        end
        else
        begin
            raddr0 = {cmd.a_slot, cnt_reg[CNT_W-1:ELEM_W], cnt_reg[IDX_W-1:0]};
        end
        raddr1 = {cmd.b_slot, cnt_reg[IDX_W-1:0], cnt_reg[ELEM_W-1:IDX_W]};
    end

    assign prod_full = rd0_reg * rd1_reg;
    assign sum_next  = ((s2_k_reg == '0) ? '0 : sum_reg) + prod_reg;
    assign sum_wr    = s2_mul_reg && (s2_k_reg == K_LAST);

    always_comb
    begin
        if (sum_wr)
        begin
            we    = 1'b1;
            waddr = {cmd.d_slot, s2_e_reg};
            wdata = sum_next;
        end
        else
        begin
            we    = cmd.load;
            waddr = {BASE_SLOT, row, col};
            wdata = value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    // sequencing of the read addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_act_reg  <= 1'b0;
            emit_act_reg <= 1'b0;
            cnt_reg      <= '0;
            s1_mul_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_mul_reg   <= 1'b0;
        end
        else
        begin
            s1_mul_reg  <= mul_act_reg;
            s1_emit_reg <= emit_act_reg;
            s2_mul_reg  <= s1_mul_reg;
            if (cmd.mul_go)
            begin
                mul_act_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (cmd.emit_go)
            begin
                emit_act_reg <= 1'b1;
                cnt_reg      <= '0;
            end
            else if (mul_act_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    mul_act_reg <= 1'b0;
                end
            end
            else if (emit_act_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg[ELEM_W-1:0] == ELEM_LAST)
                begin
                    emit_act_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_act_reg)
        begin
            s1_e_reg <= cnt_reg[ELEM_W-1:0];
        end
        else
        begin
            s1_e_reg <= cnt_reg[CNT_W-1:IDX_W];
        end
        s1_k_reg <= cnt_reg[IDX_W-1:0];
        s2_k_reg <= s1_k_reg;
        s2_e_reg <= s1_e_reg;
        prod_reg <= prod_full;
        if (s2_mul_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    // identity result when no multiply ever touched the accumulator
    assign emit_value = cmd.ident
        ? {{(DATA_W-1){1'b0}}, s1_e_reg[ELEM_W-1:IDX_W] == s1_e_reg[IDX_W-1:0]}
        : rd0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit_reg)
        begin
            out_row_reg   <= s1_e_reg[ELEM_W-1:IDX_W];
            out_col_reg   <= s1_e_reg[IDX_W-1:0];
            out_value_reg <= emit_value;
            last_reg      <= (s1_e_reg == ELEM_LAST);
        end
    end

    assign sts.mul_done  = sum_wr && (s2_e_reg == ELEM_LAST);
    assign sts.emit_done = s1_emit_reg && (s1_e_reg == ELEM_LAST);

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    `ASSERT_NEVER(a_mul_and_emit, clk, rst_n, mul_act_reg && emit_act_reg)
    `ASSERT_CLK(a_no_base_overwrite, clk, rst_n, sum_wr |-> (cmd.d_slot != BASE_SLOT))
    `ASSERT_CLK(a_last_ends_burst, clk, rst_n, (out_valid_reg && last_reg) |=> !out_valid_reg)

endmodule

// ===== sv/imp_ctrl.sv =====
// controller: exponent bookkeeping, matrix slot assignment and sequencing
`include "assert_macros.svh"

module imp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        mode,
    input  logic [imp_pkg::POW_W-1:0]   exponent,
    input  imp_pkg::sts_t               sts,
    output imp_pkg::cmd_t               cmd,
    output logic                        busy
);
    import imp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_MUL    = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [POW_W-1:0]  pow_reg;
    logic [POW_W-1:0]  pow_next;
    slot_t             acc_reg;
    slot_t             acc_next;
    slot_t             scr_reg;
    slot_t             scr_next;
    slot_t             dst_reg;
    slot_t             dst_next;
    logic              ident_reg;
    logic              ident_next;
    logic              square_reg;
    logic              square_next;
    slot_t             free_slot;
    logic              accept;
    logic              dst_ok;

    // a working slot held by neither the accumulator nor the base
    function automatic slot_t pick_free(input slot_t a, input slot_t b);
        slot_t s;
        s = slot_t'(3);
        if (a != slot_t'(2) && b != slot_t'(2))
        begin
            s = slot_t'(2);
        end
        if (a != slot_t'(1) && b != slot_t'(1))
        begin
            s = slot_t'(1);
        end
        return s;
    endfunction

    assign free_slot = pick_free(acc_reg, scr_reg);
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;

    always_comb
    begin
        state_next  = state_reg;
        pow_next    = pow_reg;
        acc_next    = acc_reg;
        scr_next    = scr_reg;
        dst_next    = dst_reg;
        ident_next  = ident_reg;
        square_next = square_reg;
        cmd.load    = 1'b0;
        cmd.mul_go  = 1'b0;
        cmd.emit_go = 1'b0;
        // operand a is the working base (the accumulator while emitting), b is the base again when squaring
        cmd.ident   = ident_reg;
        cmd.a_slot  = (state_reg == ST_EMIT) ? acc_reg : scr_reg;
        cmd.b_slot  = square_reg ? scr_reg : acc_reg;
        cmd.d_slot  = dst_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode)
                begin
                    pow_next   = exponent;
                    scr_next   = BASE_SLOT;
                    acc_next   = BASE_SLOT;
                    ident_next = 1'b1;
                    state_next = ST_DECIDE;
                end
                else if (accept)
                begin
                    cmd.load = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (pow_reg == '0)
                begin
                    cmd.emit_go = 1'b1;
                    state_next  = ST_EMIT;
                end
                else if (pow_reg[0] && ident_reg)
                begin
                    // identity times base is the base itself: just alias it
                    acc_next   = scr_reg;
                    ident_next = 1'b0;
                    pow_next   = pow_reg - 1'b1;
                end
                else
                begin
                    cmd.mul_go  = 1'b1;
                    dst_next    = free_slot;
                    square_next = !pow_reg[0];
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.mul_done)
                begin
                    if (square_reg)
                    begin
                        scr_next = dst_reg;
                        pow_next = pow_reg >> 1;
                    end
                    else
                    begin
                        acc_next = dst_reg;
                        pow_next = pow_reg - 1'b1;
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_EMIT:
            begin
                if (sts.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pow_reg    <= '0;
            acc_reg    <= BASE_SLOT;
            scr_reg    <= BASE_SLOT;
            dst_reg    <= slot_t'(1);
            ident_reg  <= 1'b1;
            square_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pow_reg    <= pow_next;
            acc_reg    <= acc_next;
            scr_reg    <= scr_next;
            dst_reg    <= dst_next;
            ident_reg  <= ident_next;
            square_reg <= square_next;
        end
    end

    assign dst_ok = (dst_reg != scr_reg) && (dst_reg != acc_reg) && (dst_reg != BASE_SLOT);

    `ASSERT_CLK(a_mul_done_in_mul, clk, rst_n, sts.mul_done |-> (state_reg == ST_MUL))
    `ASSERT_CLK(a_emit_done_in_emit, clk, rst_n, sts.emit_done |-> (state_reg == ST_EMIT))
    `ASSERT_CLK(a_dst_is_free, clk, rst_n, (state_reg == ST_MUL) |-> dst_ok)

endmodule

// ===== sv/integer_matrix_power.sv =====
// top level of the integer matrix power block
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  request  | mode, row, col, value, exponent         | start high, busy low
//  result   | out_row, out_col, out_value, last       | out_valid, one cycle each
//
// a load request writes one element of the base matrix and busy stays low. a run
// request raises busy until the last result is shown; each matrix multiply streams 64
// multiply-adds through the single 32x32 multiplier: it reads 64 operand pairs, drains
// them through the read and product registers, and returns to the decide state. the
// first odd step is free: it aliases the base, and a zero exponent emits the identity.
// the 16 results come out back to back; the receiver cannot stall them.
// reset clears control state only; the matrix memory needs no clearing pass.

module integer_matrix_power (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [imp_pkg::IDX_W-1:0]           row,
    input  logic [imp_pkg::IDX_W-1:0]           col,
    input  logic signed [imp_pkg::DATA_W-1:0]   value,
    input  logic [imp_pkg::POW_W-1:0]           exponent,
    output logic                                out_valid,
    output logic [imp_pkg::IDX_W-1:0]           out_row,
    output logic [imp_pkg::IDX_W-1:0]           out_col,
    output logic signed [imp_pkg::DATA_W-1:0]   out_value,
    output logic                                last
);
    import imp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    imp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (mode),
        .exponent (exponent),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    imp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .value     (value),
        .sts       (sts),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

endmodule
